FILE: rtl/core/rau_pkg.sv
// shared types and constants for the rational arithmetic unit
package rau_pkg;

  localparam int MagW = 32;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  // classified request between front and back
  typedef struct packed {
    logic             err;
    logic             zero;
    logic             neg;
    logic [MagW-1:0]  nm;
    logic [MagW-1:0]  dm;
  } job_t;

  localparam int JobW = $bits(job_t);
  localparam int QDepth = 2;
  localparam int QAw = 1;

endpackage

FILE: rtl/core/rau_front.sv
// front end: cross multiplication and classification of a request
module rau_front import rau_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic signed [15:0] a_num,
  input  logic signed [15:0] a_den,
  input  logic signed [15:0] b_num,
  input  logic signed [15:0] b_den,
  output logic        job_valid,
  input  logic        job_ready,
  output job_t        job
);

  // stage 1 registers: products
  logic               s1_valid;
  logic [1:0]         s1_op;
  logic               s1_bad;
  logic signed [31:0] p1, p2, pd;
  logic signed [32:0] n_sum;
  logic               busy;

  assign busy     = s1_valid || job_valid;
  assign in_ready = !busy;

  // sum or difference of products; the first product alone for mul and div
  always_comb begin
    unique case (op_t'(s1_op))
      OP_ADD:  n_sum = 33'(p1) + 33'(p2);
      OP_SUB:  n_sum = 33'(p1) - 33'(p2);
      default: n_sum = 33'(p1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      job_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
        s1_op    <= opcode;
        s1_bad   <= (a_den == 16'sd0) || (b_den == 16'sd0);
        p1 <= (op_t'(opcode) == OP_MUL) ? a_num * b_num : a_num * b_den;
        p2 <= a_den * b_num;
        pd <= (op_t'(opcode) == OP_DIV) ? a_den * b_num : a_den * b_den;
      end else if (s1_valid) begin
        s1_valid  <= 1'b0;
        job_valid <= 1'b1;
        job.err   <= s1_bad || (pd == 32'sd0);
        job.zero  <= (n_sum == 33'sd0);
        job.neg   <= n_sum[32] ^ pd[31];
        job.nm    <= n_sum[32] ? MagW'(-n_sum) : n_sum[MagW-1:0];
        job.dm    <= pd[31] ? -pd : pd;
      end else if (job_valid && job_ready) begin
        job_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/core/rau_queue.sv
// two entry queue between front and back
module rau_queue import rau_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_data
);

  job_t           mem [QDepth];
  logic [QAw-1:0] wp, rp;
  logic [QAw:0]   cnt;

  assign wr_ready = cnt != (QAw+1)'(QDepth);
  assign rd_valid = cnt != '0;
  assign rd_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem[wp] <= wr_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (wr_valid && wr_ready) wp <= wp + 1'b1;
      if (rd_valid && rd_ready) rp <= rp + 1'b1;
      cnt <= cnt + (QAw+1)'(wr_valid && wr_ready) - (QAw+1)'(rd_valid && rd_ready);
    end
  end

endmodule

FILE: rtl/core/rau_back.sv
// back end: binary gcd, exact division by gcd, sign fixup and output register
module rau_back import rau_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        job_valid,
  output logic        job_ready,
  input  job_t        job,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_data,
  output logic        out_flag
);

  typedef enum logic [2:0] {S_IDLE, S_GCD, S_DIVN, S_DIVD, S_DONE} state_t;

  state_t          state;
  logic            neg;
  logic [MagW-1:0] x, y, nm, dm, g;
  logic [MagW-1:0] rem, dvd;
  logic [5:0]      cnt;
  logic [4:0]      tz;
  logic [MagW:0]   trial;
  logic [MagW-1:0] qn;
  logic [MagW:0]   shifted;

  assign job_ready = (state == S_IDLE) && !out_valid;

  // restoring division step: one quotient bit per cycle
  assign shifted = {rem, dvd[MagW-1]};
  assign trial   = shifted - {1'b0, g};

  // signed numerator, +2^31 saturates
  assign qn = neg ? -nm : (nm[MagW-1] ? 32'h7FFF_FFFF : nm);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (job_valid && job_ready) begin
            if (job.err || job.zero) begin
              out_valid <= 1'b1;
              out_flag  <= job.err;
              out_data  <= job.err ? 64'd0 : {1'b0, 31'd1, 32'd0};
            end else begin
              neg <= job.neg; nm <= job.nm; dm <= job.dm;
              x <= job.nm; y <= job.dm; tz <= '0;
              state <= S_GCD;
            end
          end
        end
        // binary gcd: strip common twos, then halve or subtract-and-halve
        S_GCD: begin
          if (x == y) begin
            g <= x << tz; rem <= '0; dvd <= nm; cnt <= '0; state <= S_DIVN;
          end else if (!x[0] && !y[0]) begin
            x <= x >> 1; y <= y >> 1; tz <= tz + 5'd1;
          end else if (!x[0]) begin
            x <= x >> 1;
          end else if (!y[0]) begin
            y <= y >> 1;
          end else if (x > y) begin
            x <= (x - y) >> 1;
          end else begin
            y <= (y - x) >> 1;
          end
        end
        S_DIVN, S_DIVD: begin
          rem <= trial[MagW] ? shifted[MagW-1:0] : trial[MagW-1:0];
          dvd <= {dvd[MagW-2:0], !trial[MagW]};
          cnt <= cnt + 6'd1;
          if (cnt == 6'(MagW-1)) begin
            if (state == S_DIVN) begin
              nm <= {dvd[MagW-2:0], !trial[MagW]};
              rem <= '0; dvd <= dm; cnt <= '0; state <= S_DIVD;
            end else begin
              dm <= {dvd[MagW-2:0], !trial[MagW]};
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          out_valid <= 1'b1;
          out_flag  <= 1'b0;
          out_data  <= {1'b0, dm[30:0], qn};
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/rational_arith_unit_top.sv
// top level of the rational arithmetic unit
//  channel | dir | tdata fields (low bit first)                      | tuser
//  s_axis  | in  | opcode[1:0] a_num[17:2] a_den b_num b_den, pad 72 | -
//  m_axis  | out | res_num[31:0] res_den[62:32], pad 64               | zero_den_error
// the front takes a new request only after its previous job has entered the queue,
// then the back runs a binary gcd followed by two restoring divisions by the gcd,
// numerator first. errors and zero numerators are registered at the output when taken.
// reset: rst synchronous high.
// a result waits in the output register; the front keeps accepting until
// the queue and its own job register are full.
module rational_arith_unit_top import rau_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // opcode, a_num, a_den, b_num, b_den
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // res_num, res_den
  output logic        m_axis_tuser    // zero_den_error
);

  logic jv, jr, qv, qr;
  job_t jf, jq;

  rau_front u_front (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .opcode(s_axis_tdata[1:0]), .a_num(s_axis_tdata[17:2]),
    .a_den(s_axis_tdata[33:18]), .b_num(s_axis_tdata[49:34]),
    .b_den(s_axis_tdata[65:50]), .job_valid(jv), .job_ready(jr), .job(jf)
  );

  rau_queue u_queue (
    .clk, .rst, .wr_valid(jv), .wr_ready(jr), .wr_data(jf),
    .rd_valid(qv), .rd_ready(qr), .rd_data(jq)
  );

  rau_back u_back (
    .clk, .rst, .job_valid(qv), .job_ready(qr), .job(jq),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_data(m_axis_tdata), .out_flag(m_axis_tuser)
  );

endmodule
